// ===== sv/oitt_pkg.sv =====
// ----------------------------------------------------------------------------
// oitt_pkg: shared types and constants for the open ID toggle tracker
// Holds the slot geometry, field widths, command codes, controller states
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package oitt_pkg;

  // Geometry of the associative set.
  localparam int SLOTS   = 16;
  localparam int ID_BITS = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  // Port field widths.
  localparam int PID_W   = 16;
  localparam int START_W = 16;
  localparam int OPEN_W  = 5;

  // Request command codes.
  typedef enum logic {
    CMD_LOG    = 1'b0,
    CMD_REPORT = 1'b1
  } cmd_code_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMPTY
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic log_en;      // apply the incoming ID to the set
    logic scan_clear;  // restart the slot index at zero
    logic scan_step;   // advance the slot index
    logic emit;        // load the current slot into the result register
    logic emit_empty;  // load the empty-set result into the result register
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic cur_used;    // slot under the index holds an ID
    logic cur_last;    // no held slot lies above the index
    logic empty;       // the set holds no ID
    logic out_free;    // the result register can take a new result
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/oitt_ctrl.sv =====
// ----------------------------------------------------------------------------
// oitt_ctrl: controller for the open ID toggle tracker
// Takes log requests in idle, walks the slots for a report and issues the
// commands that load results into the datapath's result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oitt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                command,
  output logic                     in_stall,
  input  wire oitt_pkg::dp_status_t status,
  output oitt_pkg::dp_cmd_t        cmd
);
  import oitt_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && (command == CMD_REPORT)) begin
          state_next = status.empty ? ST_EMPTY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.cur_used && status.out_free && status.cur_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs: requests are taken only in idle.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (command == CMD_LOG) begin
            cmd.log_en = 1'b1;
          end else begin
            cmd.scan_clear = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // Unused slots are skipped; a held slot waits for the result register.
        if (status.cur_used) begin
          if (status.out_free) begin
            cmd.emit      = 1'b1;
            cmd.scan_step = !status.cur_last;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_EMPTY: begin
        cmd.emit_empty = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/oitt_dp.sv =====
// ----------------------------------------------------------------------------
// oitt_dp: datapath for the open ID toggle tracker
// Holds the slot keys and used bits, the totals, the scan index and the
// result register with its valid and stall handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module oitt_dp (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [oitt_pkg::PID_W-1:0] process_id,
  input  wire oitt_pkg::dp_cmd_t          cmd,
  output oitt_pkg::dp_status_t            status,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [oitt_pkg::PID_W-1:0]      open_id,
  output logic                           found,
  output logic                           last,
  output logic [oitt_pkg::START_W-1:0]    started_total,
  output logic [oitt_pkg::OPEN_W-1:0]     open_total,
  output logic                           overflowed
);
  import oitt_pkg::*;

  logic [ID_BITS-1:0] slot_key [SLOTS];
  logic [SLOTS-1:0]   slot_used;
  logic [START_W-1:0] start_counter;
  logic               overflow_flag;
  logic [CNT_W-1:0]   open_count;
  logic [SLOT_W-1:0]  scan_idx;

  logic [ID_BITS-1:0] id_in;
  logic [SLOTS-1:0]   hit_vec;
  logic [SLOTS-1:0]   free_vec;
  logic [SLOTS-1:0]   free_pick;
  logic               any_hit;
  logic               any_free;
  logic [SLOTS-1:0]   used_above;

  assign id_in = ID_BITS'(process_id);

  // Parallel compare against every held slot, and the lowest free slot.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i] = slot_used[i] && (slot_key[i] == id_in);
    end
  end

  assign free_vec  = ~slot_used;
  assign free_pick = free_vec & (~free_vec + SLOTS'(1));
  assign any_hit   = |hit_vec;
  assign any_free  = |free_vec;

  // Used bits, totals and the sticky overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used     <= '0;
      start_counter <= '0;
      overflow_flag <= 1'b0;
      open_count    <= '0;
    end else if (cmd.log_en) begin
      if (any_hit) begin
        slot_used  <= slot_used & ~hit_vec;
        open_count <= open_count - CNT_W'(1);
      end else if (any_free) begin
        slot_used  <= slot_used | free_pick;
        open_count <= open_count + CNT_W'(1);
        if (start_counter != '1) begin
          start_counter <= start_counter + START_W'(1);
        end
      end else begin
        overflow_flag <= 1'b1;
      end
    end
  end

  // Key store: an insert writes the ID into the chosen free slot.
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (cmd.log_en && !any_hit && free_pick[i]) begin
        slot_key[i] <= id_in;
      end
    end
  end

  // Scan index for reports.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.scan_clear) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + SLOT_W'(1);
    end
  end

  assign used_above = slot_used >> scan_idx;

  // Status back to the controller.
  always_comb begin
    status.cur_used = slot_used[scan_idx];
    status.cur_last = (used_above >> 1) == '0;
    status.empty    = (open_count == '0);
    status.out_free = !out_valid || !out_stall;
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.emit_empty) begin
      open_id       <= cmd.emit ? PID_W'(slot_key[scan_idx]) : '0;
      found         <= cmd.emit;
      last          <= cmd.emit ? status.cur_last : 1'b1;
      started_total <= start_counter;
      open_total    <= OPEN_W'(open_count);
      overflowed    <= overflow_flag;
    end
  end

endmodule

`default_nettype wire

// ===== sv/open_id_toggle_tracker.sv =====
// ----------------------------------------------------------------------------
// open_id_toggle_tracker: bounded set of IDs that toggle on every occurrence
//
//   Channel  Direction  Handshake            Fields
//   input    in         in_valid/in_stall    command, process_id
//   output   out        out_valid/out_stall  open_id, found, last,
//                                            started_total, open_total,
//                                            overflowed
//
// Log requests stream at one per cycle while no report is under way.
// A report request walks the slots one per cycle, but waits at a held slot
// while the output side stalls.
// in_stall is high for the whole report walk, including stalls on the output.
// Reset is synchronous and clears the used bits, totals and overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module open_id_toggle_tracker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       command,
  input  wire logic [oitt_pkg::PID_W-1:0]  process_id,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [oitt_pkg::PID_W-1:0]       open_id,
  output logic                            found,
  output logic                            last,
  output logic [oitt_pkg::START_W-1:0]     started_total,
  output logic [oitt_pkg::OPEN_W-1:0]      open_total,
  output logic                            overflowed
);
  import oitt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller.
  oitt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  oitt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .process_id    (process_id),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .open_id       (open_id),
    .found         (found),
    .last          (last),
    .started_total (started_total),
    .open_total    (open_total),
    .overflowed    (overflowed)
  );

`ifndef SYNTHESIS
  // An accepted report holds off further requests in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (command == CMD_REPORT)) |=> in_stall)
    else $error("report accepted without stalling the input");

  // A result without an ID is always the final one of its report.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> last)
    else $error("empty-set result not marked last");

  // A log update never coincides with loading a result.
  assert property (@(posedge clk) disable iff (rst)
    cmd.log_en |-> !(cmd.emit || cmd.emit_empty))
    else $error("log update during result load");

  // A found result carries a nonzero held count no larger than the slot count.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> ((open_total != '0) && (open_total <= OPEN_W'(SLOTS))))
    else $error("held count out of range on a report result");
`endif

endmodule

`default_nettype wire

// ===== tb/oitt_checker.sv =====
// ----------------------------------------------------------------------------
// oitt_checker: result predictor and scoreboard for the open ID toggle tracker
// Watches both channels of the block. Every accepted log request updates a
// private copy of the ID set, and every accepted report request queues the
// result lines that the block must produce. Accepted results are compared
// field by field against the oldest queued line.
// ----------------------------------------------------------------------------
module oitt_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         command,
  input  logic [oitt_pkg::PID_W-1:0]   process_id,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [oitt_pkg::PID_W-1:0]   open_id,
  input  logic                         found,
  input  logic                         last,
  input  logic [oitt_pkg::START_W-1:0] started_total,
  input  logic [oitt_pkg::OPEN_W-1:0]  open_total,
  input  logic                         overflowed,
  output int                           fail_count,
  output int                           lines_waiting
);
  import oitt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One line of a report as the block should emit it.
  typedef struct packed {
    logic [PID_W-1:0]   open_id;
    logic               found;
    logic               last;
    logic [START_W-1:0] started_total;
    logic [OPEN_W-1:0]  open_total;
    logic               overflowed;
  } report_line_t;

  // Shadow copy of the tracked set and its totals.
  logic [ID_BITS-1:0] slot_id   [SLOTS];
  logic               slot_held [SLOTS];
  logic [START_W-1:0] inserts_seen;
  logic               dropped_insert;

  report_line_t report_lines[$];
  int           fails = 0;

  initial begin
    fail_count    = 0;
    lines_waiting = 0;
  end

  // Toggle one ID: remove it if held, else insert it into the lowest free slot.
  function automatic void toggle_id(logic [ID_BITS-1:0] id);
    int free_slot;
    free_slot = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_held[s] && slot_id[s] == id) begin
        slot_held[s] = 1'b0;
        return;
      end
      if (!slot_held[s] && free_slot < 0) free_slot = s;
    end
    if (free_slot < 0) begin
      // The set is full, so the insert is dropped and the flag sticks.
      dropped_insert = 1'b1;
      return;
    end
    slot_id[free_slot]   = id;
    slot_held[free_slot] = 1'b1;
    if (inserts_seen != '1) inserts_seen = inserts_seen + 1'b1;
  endfunction

  function automatic report_line_t make_line(logic [PID_W-1:0] id, logic hit,
                                             logic tail, int held);
    report_line_t line;
    line.open_id       = id;
    line.found         = hit;
    line.last          = tail;
    line.started_total = inserts_seen;
    line.open_total    = OPEN_W'(held);
    line.overflowed    = dropped_insert;
    return line;
  endfunction

  // Append one expected line at the tail of the queue.
  function automatic void append_line(report_line_t line);
    report_lines.insert(report_lines.size(), line);
  endfunction

  // Queue every held ID in slot order, or a single not-found line if empty.
  function automatic void queue_report();
    int held;
    int seen;
    held = 0;
    seen = 0;
    for (int s = 0; s < SLOTS; s++) if (slot_held[s]) held++;
    if (held == 0) begin
      append_line(make_line('0, 1'b0, 1'b1, 0));
      return;
    end
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_held[s]) begin
        seen++;
        append_line(make_line(PID_W'(slot_id[s]), 1'b1, seen == held, held));
      end
    end
  endfunction

  function automatic int field_differs(string name, longint unsigned want,
                                       longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Requests are applied before results are checked, so that a result can
  // never overtake the request that causes it.
  always @(posedge clk) begin : watch
    report_line_t want;
    int           bad;
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_id[s]   = '0;
        slot_held[s] = 1'b0;
      end
      inserts_seen   = '0;
      dropped_insert = 1'b0;
      report_lines.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (cmd_code_t'(command) == CMD_LOG) toggle_id(process_id[ID_BITS-1:0]);
        else queue_report();
      end
      if (out_valid && !out_stall) begin
        if (report_lines.size() == 0) begin
          $error("result with open_id 0x%0h arrived with no report pending", open_id);
          fails++;
        end else begin
          want = report_lines.pop_front();
          bad  = field_differs("open_id", want.open_id, open_id)
               + field_differs("found", want.found, found)
               + field_differs("last", want.last, last)
               + field_differs("started_total", want.started_total, started_total)
               + field_differs("open_total", want.open_total, open_total)
               + field_differs("overflowed", want.overflowed, overflowed);
          fails += bad;
        end
      end
    end
    fail_count    <= fails;
    lines_waiting <= report_lines.size();
  end

endmodule

// ===== tb/open_id_toggle_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// open_id_toggle_tracker_tb: stimulus and verdict for the open ID toggle tracker
// Drives directed log and report requests, two random phases with small and
// large ID pools and a fill that overflows the set, with random gaps and
// output stalls throughout.
// Checking is done by oitt_checker.
// ----------------------------------------------------------------------------
module open_id_toggle_tracker_tb;
  import oitt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int POOL_SIZE  = 24;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               command;
  logic [PID_W-1:0]   process_id;
  logic               out_valid;
  logic               out_stall;
  logic [PID_W-1:0]   open_id;
  logic               found;
  logic               last;
  logic [START_W-1:0] started_total;
  logic [OPEN_W-1:0]  open_total;
  logic               overflowed;

  int fail_count;
  int lines_waiting;
  int idle_cycles;
  int stall_left;
  bit quiet;

  logic [PID_W-1:0] id_pool [POOL_SIZE];

  open_id_toggle_tracker i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .process_id    (process_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .open_id       (open_id),
    .found         (found),
    .last          (last),
    .started_total (started_total),
    .open_total    (open_total),
    .overflowed    (overflowed)
  );

  oitt_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .process_id    (process_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .open_id       (open_id),
    .found         (found),
    .last          (last),
    .started_total (started_total),
    .open_total    (open_total),
    .overflowed    (overflowed),
    .fail_count    (fail_count),
    .lines_waiting (lines_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Length of a pause: mostly short, now and then long.
  function automatic int pause_len();
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Output side stalls at random, except in quiet stretches.
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < 7) begin
      out_stall <= 1'b0;
    end else begin
      out_stall  <= 1'b1;
      stall_left <= pause_len() - 1;
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request, after an optional gap, and hold it until accepted.
  task automatic send_request(cmd_code_t cmd, logic [PID_W-1:0] id);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 9) < 4) gap = pause_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    process_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly logs drawn from the first pool_n pool entries, some reports, and
  // when any_id is set a share of fully random IDs.
  task automatic run_random(int count, int pool_n, bit any_id);
    logic [PID_W-1:0] id;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 15) begin
        send_request(CMD_REPORT, PID_W'($urandom));
      end else begin
        id = id_pool[$urandom_range(0, pool_n - 1)];
        if (any_id && $urandom_range(0, 9) == 0) id = PID_W'($urandom);
        send_request(CMD_LOG, id);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    command    = CMD_LOG;
    process_id = '0;
    out_stall  = 1'b0;
    quiet      = 1'b0;
    for (int p = 0; p < POOL_SIZE; p++) id_pool[p] = PID_W'($urandom);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty report, extreme IDs, removal from the middle, slot reuse.
    send_request(CMD_REPORT, 16'hFFFF);
    send_request(CMD_LOG, 16'h0000);
    send_request(CMD_LOG, 16'hFFFF);
    send_request(CMD_LOG, 16'hAAAA);
    send_request(CMD_LOG, 16'h5555);
    send_request(CMD_REPORT, 16'h0000);
    send_request(CMD_LOG, 16'hFFFF);
    send_request(CMD_REPORT, 16'h1234);
    send_request(CMD_LOG, 16'h1234);
    send_request(CMD_REPORT, 16'hFFFF);
    send_request(CMD_LOG, 16'h0000);
    send_request(CMD_LOG, 16'hAAAA);
    send_request(CMD_LOG, 16'h5555);
    send_request(CMD_LOG, 16'h1234);
    send_request(CMD_REPORT, 16'h0000);

    // Small pool: the set never fills, so the overflow flag stays clear.
    run_random(160, 14, 1'b0);

    // Fill the set with fresh IDs, then keep inserting into the full set.
    for (int k = 0; k < 20; k++) begin
      send_request(CMD_LOG, PID_W'(16'hC000 + k * 16'h0101));
      if (k == 15) send_request(CMD_REPORT, '0);
    end
    send_request(CMD_REPORT, '0);

    // Large pool with random IDs mixed in: overflow, removals and refills.
    run_random(160, POOL_SIZE, 1'b1);
    send_request(CMD_REPORT, '0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (lines_waiting != 0) @(posedge clk);
    repeat (4 * SLOTS) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
